// File: hw/rtl/conv2d_valid_stream_core_assert.svh
// Assertion macros shared by the convolution core RTL.
`ifndef CONV2D_VALID_STREAM_CORE_ASSERT_SVH
`define CONV2D_VALID_STREAM_CORE_ASSERT_SVH

// Implication that must hold on every clock edge out of reset.
`define C2D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Signal must be low on the edge after reset has been seen low.
`define C2D_ASSERT_RST(lbl, clk, rstn, sig, msg) \
  lbl: assert property (@(posedge clk) (!(rstn)) |=> (!(sig))) else $error(msg);

`endif

// File: hw/rtl/c2dv_pkg.sv
// ----------------------------------------------------------------------------
// c2dv_pkg
// Shared constants and types for the valid-mode convolution core.
// ----------------------------------------------------------------------------
`default_nettype none
package c2dv_pkg;
  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 1024;
  localparam int unsigned MaxKernel  = 8;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned RowBits    = $clog2(MaxHeight);
  localparam int unsigned KBits      = $clog2(MaxKernel);
  localparam int unsigned ResBits    = 38;
  localparam int unsigned ProdBits   = 2 * SampleBits;

  typedef enum logic [1:0] {
    RegWidth   = 2'd0,
    RegHeight  = 2'd1,
    RegKHeight = 2'd2,
    RegKWidth  = 2'd3
  } reg_idx_e;

  // Control of one window beat through the MAC pipeline
  typedef struct packed {
    logic               vld;
    logic               emit;
    logic               last;
    logic [RowBits-1:0] row;
    logic [ColBits-1:0] col;
  } tag_t;
endpackage
`default_nettype wire

// File: hw/rtl/conv2d_valid_stream_core.sv
// ----------------------------------------------------------------------------
// conv2d_valid_stream_core
// Streaming valid-mode 2D correlation over a line-buffered pixel stream.
// ----------------------------------------------------------------------------
// Input beats (s_axis): tuser = action; 0 = pixel, 1 = coefficient load.
// Pixels arrive row-major. Each pixel completing a kernel window yields one
// output beat (m_axis) with sum, row, column and tlast on the frame's last.
// Throughput: one beat per cycle while the output is not stalled; a coefficient
// beat straight after a pixel waits while that pixel sits in stage 0, so that
// the pixel is multiplied with the old kernel. Registers in order: line memory
// read, window shift, multiply, row sum, total, then the output register.
// The pipeline advances only when the output register is free or taken,
// so a stalled receiver back-pressures s_axis_tready; no beat is dropped.
// The window is fed from a column read of the line memory (one bank per
// kernel row); the new pixel is forwarded in place of its stale entry.
// Reset clears the kernel to zero, position to (0,0), registers to
// 1024/1024/3/3. Any register write restarts the frame at (0,0).
// Kernels larger than the image never produce output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "conv2d_valid_stream_core_assert.svh"
module conv2d_valid_stream_core import c2dv_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [10:0]       cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,  // sample, coefficient, coef_row, coef_col
  input  wire logic              s_axis_tuser,  // action
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [63:0]            m_axis_tdata,  // result, out_row, out_col
  output logic                   m_axis_tlast
);
  logic [10:0] w_q, h_q;
  logic [3:0]  kh_q, kw_q;
  logic [ColBits-1:0] w, kw;
  logic [RowBits-1:0] h, kh;
  logic [RowBits-1:0] row_q;
  logic [ColBits-1:0] col_q;
  logic signed [SampleBits-1:0] kern_q [MaxKernel][MaxKernel];
  logic en, acc, pix;
  logic signed [SampleBits-1:0] smp, coef;
  logic [KBits-1:0] krow, kcol;
  tag_t tag0_q, tag_o;

  assign smp  = s_axis_tdata[15:0];
  assign coef = s_axis_tdata[31:16];
  assign krow = s_axis_tdata[34:32];
  assign kcol = s_axis_tdata[37:35];

  // Effective register values: 0 acts as 1, above max acts as max
  function automatic logic [10:0] clampv(logic [10:0] v, logic [10:0] hi);
    logic [10:0] r;
    r = (v == '0) ? 11'd1 : ((v > hi) ? hi : v);
    return r;
  endfunction
  logic [10:0] wc, hc, khc, kwc;
  assign wc  = clampv(w_q, 11'(MaxWidth));
  assign hc  = clampv(h_q, 11'(MaxHeight));
  assign khc = clampv({7'd0, kh_q}, 11'(MaxKernel));
  assign kwc = clampv({7'd0, kw_q}, 11'(MaxKernel));
  assign w  = ColBits'(wc - 11'd1);  // stored minus one
  assign h  = RowBits'(hc - 11'd1);
  assign kw = ColBits'(kwc - 11'd1);
  assign kh = RowBits'(khc - 11'd1);

  // Output register free or being taken
  assign en  = !m_axis_tvalid || m_axis_tready;
  // Kernel is read at the multiply stage: hold a coefficient while a pixel
  // sits in stage 0
  assign s_axis_tready = en && !(s_axis_tuser && tag0_q.vld);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign pix = acc && !s_axis_tuser;

  logic [RowBits-1:0] r_eff;
  logic [ColBits-1:0] c_eff;
  assign r_eff = (row_q > h || col_q > w) ? '0 : row_q;
  assign c_eff = (row_q > h || col_q > w) ? '0 : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= 11'd1024; h_q <= 11'd1024; kh_q <= 4'd3; kw_q <= 4'd3;
      row_q <= '0; col_q <= '0;
      for (int r = 0; r < MaxKernel; r++)
        for (int c = 0; c < MaxKernel; c++) kern_q[r][c] <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegWidth:   w_q  <= cfg_data_i;
        RegHeight:  h_q  <= cfg_data_i;
        RegKHeight: kh_q <= cfg_data_i[3:0];
        RegKWidth:  kw_q <= cfg_data_i[3:0];
        default: ;
      endcase
      row_q <= '0; col_q <= '0;
    end else if (acc) begin
      if (s_axis_tuser) kern_q[krow][kcol] <= coef;
      else if (c_eff == w) begin
        col_q <= '0;
        row_q <= (r_eff == h) ? '0 : r_eff + 1'b1;
      end else begin
        row_q <= r_eff; col_q <= c_eff + 1'b1;
      end
    end
  end

  // Stage 0: memory read, tag and forwarding data registered
  logic signed [SampleBits-1:0] rd [MaxKernel];
  c2dv_line_mem u_mem (
    .clk_i, .we_i(pix), .wbank_i(r_eff[KBits-1:0]), .addr_i(c_eff),
    .wdata_i(smp), .re_i(en), .rdata_o(rd)
  );

  logic [KBits-1:0] bank0_q;
  logic signed [SampleBits-1:0] smp0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tag0_q <= '0;
    else if (en) begin
      tag0_q.vld  <= pix;
      tag0_q.emit <= pix && r_eff >= kh && c_eff >= kw;
      tag0_q.last <= r_eff == h && c_eff == w;
      tag0_q.row  <= r_eff - kh;
      tag0_q.col  <= c_eff - kw;
    end
  end
  always_ff @(posedge clk_i) if (en) begin
    bank0_q <= r_eff[KBits-1:0] - kh[KBits-1:0];
    smp0_q  <= smp;
  end

  // Column for window: kernel row k reads bank (top + k); newest row forwarded
  logic signed [SampleBits-1:0] colv [MaxKernel];
  always_comb begin
    for (int k = 0; k < MaxKernel; k++) begin
      colv[k] = rd[KBits'(bank0_q + KBits'(k))];
      if (KBits'(k) == kh[KBits-1:0]) colv[k] = smp0_q;
    end
  end

  // Kernel aligned to the window: window column 0 is the newest, so kernel
  // columns run backwards; entries outside the kernel size count as zero
  logic signed [SampleBits-1:0] kmap [MaxKernel][MaxKernel];
  always_comb begin
    for (int r = 0; r < MaxKernel; r++)
      for (int c = 0; c < MaxKernel; c++) begin
        kmap[r][c] = '0;
        if (KBits'(r) <= kh[KBits-1:0] && KBits'(c) <= kw[KBits-1:0])
          kmap[r][c] = kern_q[r][kw[KBits-1:0] - KBits'(c)];
      end
  end

  logic signed [ResBits-1:0] sum;
  c2dv_mac u_mac (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag0_q), .col_i(colv),
    .kern_i(kmap), .tag_o(tag_o), .sum_o(sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= tag_o.emit;
  end
  always_ff @(posedge clk_i) if (en) begin
    m_axis_tdata <= {6'd0, tag_o.col, tag_o.row, sum};
    m_axis_tlast <= tag_o.last;
  end

  `C2D_ASSERT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output beat lost under stall")
  `C2D_ASSERT(a_ready, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")
  `C2D_ASSERT(a_emit, clk_i, rst_ni, tag_o.emit |-> tag_o.vld, "output from non-pixel beat")
  `C2D_ASSERT_RST(a_rst, clk_i, rst_ni, m_axis_tvalid, "valid during reset")
endmodule
`default_nettype wire

// File: hw/rtl/c2dv_line_mem.sv
// ----------------------------------------------------------------------------
// c2dv_line_mem
// Line store: one memory bank per kernel row, all read at one column.
// ----------------------------------------------------------------------------
`default_nettype none
module c2dv_line_mem import c2dv_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [KBits-1:0]             wbank_i,
  input  wire logic [ColBits-1:0]           addr_i,
  input  wire logic signed [SampleBits-1:0] wdata_i,
  input  wire logic                         re_i,
  output logic signed [SampleBits-1:0]      rdata_o [MaxKernel]
);
  for (genvar b = 0; b < MaxKernel; b++) begin : g_bank
    logic signed [SampleBits-1:0] mem [MaxWidth];
    always_ff @(posedge clk_i) begin
      if (we_i && wbank_i == KBits'(b)) begin
        mem[addr_i] <= wdata_i;
      end
      if (re_i) begin
        rdata_o[b] <= mem[addr_i];
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/c2dv_mac.sv
// ----------------------------------------------------------------------------
// c2dv_mac
// Window shift register and pipelined multiply/adder tree.
// ----------------------------------------------------------------------------
`default_nettype none
module c2dv_mac import c2dv_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire tag_t                         tag_i,
  input  wire logic signed [SampleBits-1:0] col_i [MaxKernel],
  input  wire logic signed [SampleBits-1:0] kern_i [MaxKernel][MaxKernel],
  output tag_t                              tag_o,
  output logic signed [ResBits-1:0]         sum_o
);
  // win_q[r][c]: c = 0 holds the newest column
  logic signed [SampleBits-1:0] win_q [MaxKernel][MaxKernel];
  logic signed [ProdBits-1:0]   prod_q [MaxKernel][MaxKernel];
  logic signed [ResBits-1:0]    rsum_q [MaxKernel];
  logic signed [ResBits-1:0]    sum_q;
  tag_t t1_q, t2_q, t3_q, t4_q;
  logic signed [ResBits-1:0]    rs_d [MaxKernel];
  logic signed [ResBits-1:0]    s_d;

  always_ff @(posedge clk_i) begin
    if (en_i && tag_i.vld) begin
      for (int r = 0; r < MaxKernel; r++) begin
        win_q[r][0] <= col_i[r];
        for (int c = 1; c < MaxKernel; c++) win_q[r][c] <= win_q[r][c-1];
      end
    end
    if (en_i) begin
      for (int r = 0; r < MaxKernel; r++)
        for (int c = 0; c < MaxKernel; c++)
          prod_q[r][c] <= win_q[r][c] * kern_i[r][c];
      rsum_q <= rs_d;
      sum_q  <= s_d;
    end
  end

  always_comb begin
    for (int r = 0; r < MaxKernel; r++) begin
      rs_d[r] = '0;
      for (int c = 0; c < MaxKernel; c++) rs_d[r] = rs_d[r] + ResBits'(prod_q[r][c]);
    end
    s_d = '0;
    for (int r = 0; r < MaxKernel; r++) s_d = s_d + rsum_q[r];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0;
    end else if (en_i) begin
      t1_q <= tag_i; t2_q <= t1_q; t3_q <= t2_q; t4_q <= t3_q;
    end
  end

  assign tag_o = t4_q;
  assign sum_o = sum_q;
endmodule
`default_nettype wire

// File: verif/tb_conv2d_valid_stream_core.sv
// ----------------------------------------------------------------------------
// tb_conv2d_valid_stream_core
// Self-checking bench for the valid-mode convolution core: a queue-fed beat
// driver, a monitor that scoreboards against an in-bench window predictor,
// random stall bursts on both streams and several register settings.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_conv2d_valid_stream_core;
  import c2dv_pkg::*;

  typedef struct packed {
    logic        action;
    logic [15:0] sample;
    logic [15:0] coef;
    logic [2:0]  krow;
    logic [2:0]  kcol;
  } pix_beat_t;

  typedef struct packed {
    logic [37:0] sum;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
  } conv_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // sample, coefficient, coef_row, coef_col
  logic        s_axis_tuser = 1'b0; // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // result, out_row, out_col
  logic        m_axis_tlast;

  conv2d_valid_stream_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state
  logic signed [15:0] line_mem [MaxKernel][MaxWidth];
  logic signed [15:0] kern_mem [MaxKernel][MaxKernel];
  int unsigned img_w, img_h, k_h, k_w, pos_r, pos_c;

  pix_beat_t pending_beats[$];
  conv_out_t expected_sums[$];
  int  err_cnt = 0;
  longint cycle_cnt = 0;
  bit  no_idle = 1'b0;
  int  tx_gap = 0, rx_gap = 0;

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Updates the window model for one accepted beat; may queue a result
  function automatic void predict_beat(pix_beat_t b);
    int unsigned w, h, kh, kw, r, c, i, j;
    longint acc;
    conv_out_t o;
    w = clip(img_w, MaxWidth); h = clip(img_h, MaxHeight);
    kh = clip(k_h, MaxKernel); kw = clip(k_w, MaxKernel);
    if (b.action) begin
      kern_mem[b.krow][b.kcol] = b.coef;
      return;
    end
    r = pos_r; c = pos_c;
    if (r >= h || c >= w) begin
      r = 0; c = 0;
    end
    line_mem[r % MaxKernel][c] = b.sample;
    if (r + 1 >= kh && c + 1 >= kw) begin
      i = r + 1 - kh; j = c + 1 - kw; acc = 0;
      for (int a = 0; a < kh; a++)
        for (int d = 0; d < kw; d++)
          acc += longint'(line_mem[(i + a) % MaxKernel][j + d]) * longint'(kern_mem[a][d]);
      o.sum = acc[37:0]; o.row = i[9:0]; o.col = j[9:0];
      o.last = (r + 1 == h && c + 1 == w);
      expected_sums.push_back(o);
    end
    if (c + 1 >= w) begin
      c = 0; r = (r + 1 >= h) ? 0 : r + 1;
    end else c++;
    pos_r = r; pos_c = c;
  endfunction

  task automatic report_err(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0h exp %0h at cycle %0d", what, got, exp_v, cycle_cnt);
    err_cnt++;
  endtask

  // Driver: beat presented from the queue head, random gap bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(pending_beats.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // beat still waiting: held unchanged
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!no_idle && $urandom_range(15) == 0) begin
        tx_gap <= $urandom_range(15, 1) - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, pending_beats[0].kcol, pending_beats[0].krow,
                         pending_beats[0].coef, pending_beats[0].sample};
        s_axis_tuser <= pending_beats[0].action;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and sink stall bursts
  always @(posedge clk_i) begin
    conv_out_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sums.size() == 0) report_err("unexpected beat", m_axis_tdata, 0);
        else begin
          e = expected_sums.pop_front();
          if (m_axis_tdata[37:0] !== e.sum) report_err("result", m_axis_tdata[37:0], e.sum);
          if (m_axis_tdata[47:38] !== e.row) report_err("out_row", m_axis_tdata[47:38], e.row);
          if (m_axis_tdata[57:48] !== e.col) report_err("out_col", m_axis_tdata[57:48], e.col);
          if (m_axis_tlast !== e.last) report_err("tlast", m_axis_tlast, e.last);
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(12) == 0) begin
        rx_gap <= $urandom_range(15, 1) - 1;
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
    if (cycle_cnt > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegWidth:   img_w = val & 11'h7ff;
      RegHeight:  img_h = val & 11'h7ff;
      RegKHeight: k_h = val & 4'hf;
      default:    k_w = val & 4'hf;
    endcase
    pos_r = 0; pos_c = 0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || s_axis_tvalid || expected_sums.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic void add_coef(logic [15:0] v, logic [2:0] kr, logic [2:0] kc);
    pix_beat_t b;
    b = '0; b.action = 1'b1; b.coef = v; b.krow = kr; b.kcol = kc;
    b.sample = 16'($urandom);
    pending_beats.push_back(b);
  endfunction

  function automatic void add_pix(logic [15:0] v);
    pix_beat_t b;
    b = {1'b0, v, 16'($urandom), 3'($urandom), 3'($urandom)};
    pending_beats.push_back(b);
  endfunction

  // Full frame with a random kernel; pixel values random or extreme
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned kh, int unsigned kw);
    int unsigned ew, eh;
    write_reg(RegWidth, w); write_reg(RegHeight, h);
    write_reg(RegKHeight, kh); write_reg(RegKWidth, kw);
    for (int a = 0; a < 8; a++)
      for (int d = 0; d < 8; d++)
        if ($urandom_range(3) != 0) add_coef(16'($urandom), 3'(a), 3'(d));
    ew = clip(w & 11'h7ff, MaxWidth); eh = clip(h & 11'h7ff, MaxHeight);
    for (int p = 0; p < ew * eh; p++) begin
      case ($urandom_range(5))
        0: add_pix(16'h8000);
        1: add_pix(16'h7fff);
        default: add_pix(16'($urandom));
      endcase
    end
    drain();
  endtask

  initial begin
    int unsigned sent;
    img_w = 1024; img_h = 1024; k_h = 3; k_w = 3; pos_r = 0; pos_c = 0;
    foreach (kern_mem[a, d]) kern_mem[a][d] = '0;
    foreach (line_mem[a, d]) line_mem[a][d] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extreme values, 2x2 kernel of -32768 and 32767 on alternating -32768 and 32767 pixels
    write_reg(RegWidth, 4); write_reg(RegHeight, 3);
    write_reg(RegKHeight, 2); write_reg(RegKWidth, 2);
    add_coef(16'h8000, 0, 0); add_coef(16'h8000, 0, 1);
    add_coef(16'h7fff, 1, 0); add_coef(16'h8000, 1, 1);
    add_coef(16'h1234, 7, 7);
    for (int p = 0; p < 12; p++) add_pix(p[0] ? 16'h7fff : 16'h8000);
    drain();
    // Register extremes: zero acts as one, over-range clips; kernel bigger than image
    run_frame(0, 0, 0, 0);
    run_frame(5, 2, 15, 1);
    run_frame(3, 3, 8, 8);
    run_frame(9, 8, 8, 8);
    run_frame(40, 1, 1, 8);
    // Random part
    sent = 0;
    while (sent < 120) begin
      int unsigned w, h;
      w = $urandom_range(9, 1); h = $urandom_range(9, 1);
      if (sent > 90) no_idle = 1'b1;
      run_frame(w, h, $urandom_range(8, 1), $urandom_range(8, 1));
      sent += w * h;
    end
    drain();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
